[rtl/core/pixel_command_serializer_assert.svh]
// Assertion macros for the pixel command serializer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PIXEL_COMMAND_SERIALIZER_ASSERT_SVH
`define PIXEL_COMMAND_SERIALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PCS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_command_serializer: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PCS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_command_serializer: next-cycle check failed");

`endif

[rtl/core/pcs_pkg.sv]
// Shared types and constants of the pixel command serializer.
// No dependencies; every other file but the assertion header uses it by scoped names.
`default_nettype none

package pcs_pkg;

    // Field widths of the pixel and byte transactions
    localparam int unsigned COORD_BITS = 16;
    localparam int unsigned COLOR_BITS = 8;
    localparam int unsigned BYTE_BITS  = 8;

    // Decimal digits of the widest coordinate and the width of a digit index
    localparam int unsigned DEC_DIGITS = 5;
    localparam int unsigned DIG_IDX_W  = 3;

    // Position counter of the byte sequencer
    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] HEAD_LAST = 3'd2;
    localparam logic [CNT_W-1:0] HEX_LAST  = 3'd5;
    localparam logic [CNT_W-1:0] BIN_LAST  = 3'd7;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;

    // Configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_BINARY_MODE = 1'b0;

    // Characters of the text command
    localparam logic [7:0] CH_P        = 8'h50;
    localparam logic [7:0] CH_X        = 8'h58;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;

    // One classified pixel, ready to be serialized
    typedef struct packed {
        logic                                binary_mode;
        logic [COORD_BITS-1:0]               x_coord;
        logic [COORD_BITS-1:0]               y_coord;
        logic [COLOR_BITS-1:0]               red;
        logic [COLOR_BITS-1:0]               green;
        logic [COLOR_BITS-1:0]               blue;
        logic [DEC_DIGITS-1:0][3:0]          x_dig;
        logic [DEC_DIGITS-1:0][3:0]          y_dig;
        logic [DIG_IDX_W-1:0]                x_top;
        logic [DIG_IDX_W-1:0]                y_top;
    } pcs_cmd_t;

    // Byte sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_XDIG,
        ST_SEP1,
        ST_YDIG,
        ST_SEP2,
        ST_HEX,
        ST_NL,
        ST_BIN
    } pcs_state_t;

endpackage

`default_nettype wire

[rtl/core/pcs_if.sv]
// Channel interfaces of the pixel command serializer: pixel in, bytes out.
// Depends on pcs_pkg for field widths.
`default_nettype none

interface pcs_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [pcs_pkg::COORD_BITS-1:0]   x_coord;
    logic [pcs_pkg::COORD_BITS-1:0]   y_coord;
    logic [pcs_pkg::COLOR_BITS-1:0]   red;
    logic [pcs_pkg::COLOR_BITS-1:0]   green;
    logic [pcs_pkg::COLOR_BITS-1:0]   blue;

    modport source (output valid, output x_coord, output y_coord,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input x_coord, input y_coord,
                    input red, input green, input blue, output ready);
endinterface

interface pcs_byte_if;
    logic                             valid;
    logic                             ready;
    logic [pcs_pkg::BYTE_BITS-1:0]    out_byte;
    logic                             last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/pcs_front.sv]
// Front end: accepts pixels and converts both coordinates to decimal digits,
// one digit per pipeline stage. Depends on pcs_pkg and pcs_pixel_if.
`default_nettype none

module pcs_front #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              binary_mode,
    pcs_pixel_if.sink         pixel_in,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output pcs_pkg::pcs_cmd_t cmd_data
);

    localparam int unsigned NDIG = pcs_pkg::DEC_DIGITS;
    localparam int unsigned CW   = pcs_pkg::COORD_BITS;
    localparam logic [CW-1:0] COORD_MASK = CW'((32'd1 << COORD_WIDTH) - 32'd1);

    typedef struct packed {
        logic                            binary_mode;
        logic [CW-1:0]                   x_coord;
        logic [CW-1:0]                   y_coord;
        logic [CW-1:0]                   x_rem;
        logic [CW-1:0]                   y_rem;
        logic [pcs_pkg::COLOR_BITS-1:0]  red;
        logic [pcs_pkg::COLOR_BITS-1:0]  green;
        logic [pcs_pkg::COLOR_BITS-1:0]  blue;
        logic [NDIG-1:0][3:0]            x_dig;
        logic [NDIG-1:0][3:0]            y_dig;
    } stage_t;

    // Quotient by ten through the reciprocal 52429 / 2^19, exact below 81920
    function automatic logic [CW-1:0] div10(input logic [CW-1:0] v);
        logic [31:0] prod;
        begin
            prod = 32'(v) * 32'd52429;
            return CW'(prod[31:19]);
        end
    endfunction

    stage_t          st_reg [NDIG];
    logic [NDIG-1:0] vld_reg;
    stage_t          head;
    logic            advance;

    // Move the whole pipeline unless the last stage is blocked
    assign advance        = !vld_reg[NDIG-1] || cmd_ready;
    assign pixel_in.ready = advance;

    // Mask the coordinates and capture the mode with the transaction
    always_comb
    begin
        head             = '0;
        head.binary_mode = binary_mode;
        head.x_coord     = pixel_in.x_coord & COORD_MASK;
        head.y_coord     = pixel_in.y_coord & COORD_MASK;
        head.x_rem       = pixel_in.x_coord & COORD_MASK;
        head.y_rem       = pixel_in.y_coord & COORD_MASK;
        head.red         = pixel_in.red;
        head.green       = pixel_in.green;
        head.blue        = pixel_in.blue;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NDIG-2:0], pixel_in.valid};
        end
    end

    // Each stage peels off one decimal digit of x and of y
    for (genvar k = 0; k < NDIG; k++)
    begin : g_stage
        stage_t        src;
        stage_t        nxt;
        logic [CW-1:0] qx;
        logic [CW-1:0] qy;
        logic [CW-1:0] rx;
        logic [CW-1:0] ry;

        if (k == 0)
        begin : g_first
            assign src = head;
        end
        else
        begin : g_rest
            assign src = st_reg[k-1];
        end

        always_comb
        begin
            qx = div10(src.x_rem);
            qy = div10(src.y_rem);
            rx = src.x_rem - ((qx << 3) + (qx << 1));
            ry = src.y_rem - ((qy << 3) + (qy << 1));
            nxt          = src;
            nxt.x_rem    = qx;
            nxt.y_rem    = qy;
            nxt.x_dig[k] = rx[3:0];
            nxt.y_dig[k] = ry[3:0];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[k] <= nxt;
            end
        end
    end

    // Find the leading digit and hand the command to the queue
    always_comb
    begin
        logic [pcs_pkg::DIG_IDX_W-1:0] x_top;
        logic [pcs_pkg::DIG_IDX_W-1:0] y_top;
        x_top = '0;
        y_top = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (st_reg[NDIG-1].x_dig[i] != 4'd0)
            begin
                x_top = pcs_pkg::DIG_IDX_W'(i);
            end
            if (st_reg[NDIG-1].y_dig[i] != 4'd0)
            begin
                y_top = pcs_pkg::DIG_IDX_W'(i);
            end
        end
        cmd_data.binary_mode = st_reg[NDIG-1].binary_mode;
        cmd_data.x_coord     = st_reg[NDIG-1].x_coord;
        cmd_data.y_coord     = st_reg[NDIG-1].y_coord;
        cmd_data.red         = st_reg[NDIG-1].red;
        cmd_data.green       = st_reg[NDIG-1].green;
        cmd_data.blue        = st_reg[NDIG-1].blue;
        cmd_data.x_dig       = st_reg[NDIG-1].x_dig;
        cmd_data.y_dig       = st_reg[NDIG-1].y_dig;
        cmd_data.x_top       = x_top;
        cmd_data.y_top       = y_top;
    end

    assign cmd_valid = vld_reg[NDIG-1];

endmodule

`default_nettype wire

[rtl/core/pcs_queue.sv]
// Short command queue between the front end and the byte sequencer.
// Depends on pcs_pkg for the command type and depth.
`default_nettype none

module pcs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcs_pkg::pcs_cmd_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pcs_pkg::pcs_cmd_t out_data
);

    localparam int unsigned PW = pcs_pkg::QPTR_W;

    pcs_pkg::pcs_cmd_t entries_reg [pcs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != (PW+1)'(pcs_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pcs_back.sv]
// Back end: walks one command byte by byte into an output register.
// Depends on pcs_pkg and pcs_byte_if.
`default_nettype none

module pcs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pcs_pkg::pcs_cmd_t cmd_data,
    pcs_byte_if.source        byte_out
);

    pcs_pkg::pcs_state_t            state_reg;
    pcs_pkg::pcs_state_t            state_next;
    logic [pcs_pkg::CNT_W-1:0]      cnt_reg;
    logic [pcs_pkg::CNT_W-1:0]      cnt_next;
    pcs_pkg::pcs_cmd_t              cmd_reg;
    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           out_last_reg;

    logic                           out_free;
    logic                           busy;
    logic                           is_last;
    logic                           load;
    logic [7:0]                     emit_byte;
    logic [3:0]                     nib;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        begin
            return 8'(n) + ((n < 4'd10) ? pcs_pkg::CH_ZERO : pcs_pkg::HEX_ALPHA_OFS);
        end
    endfunction

    assign out_free = !out_valid_reg || byte_out.ready;
    assign busy     = state_reg != pcs_pkg::ST_IDLE;
    assign load     = cmd_valid && cmd_ready;

    // Outputs: current byte, last flag and command pop
    always_comb
    begin
        is_last   = (state_reg == pcs_pkg::ST_NL) ||
                    ((state_reg == pcs_pkg::ST_BIN) && (cnt_reg == pcs_pkg::BIN_LAST));
        cmd_ready = !busy || (out_free && is_last);

        unique case (cnt_reg)
            3'd0:    nib = cmd_reg.red[7:4];
            3'd1:    nib = cmd_reg.red[3:0];
            3'd2:    nib = cmd_reg.green[7:4];
            3'd3:    nib = cmd_reg.green[3:0];
            3'd4:    nib = cmd_reg.blue[7:4];
            default: nib = cmd_reg.blue[3:0];
        endcase

        unique case (state_reg)
            pcs_pkg::ST_HEAD:
            begin
                unique case (cnt_reg)
                    3'd0:    emit_byte = pcs_pkg::CH_P;
                    3'd1:    emit_byte = pcs_pkg::CH_X;
                    default: emit_byte = pcs_pkg::CH_SPACE;
                endcase
            end
            pcs_pkg::ST_XDIG: emit_byte = pcs_pkg::CH_ZERO + 8'(cmd_reg.x_dig[cnt_reg]);
            pcs_pkg::ST_YDIG: emit_byte = pcs_pkg::CH_ZERO + 8'(cmd_reg.y_dig[cnt_reg]);
            pcs_pkg::ST_SEP1: emit_byte = pcs_pkg::CH_SPACE;
            pcs_pkg::ST_SEP2: emit_byte = pcs_pkg::CH_SPACE;
            pcs_pkg::ST_HEX:  emit_byte = hex_char(nib);
            pcs_pkg::ST_NL:   emit_byte = pcs_pkg::CH_NEWLINE;
            pcs_pkg::ST_BIN:
            begin
                unique case (cnt_reg)
                    3'd0:    emit_byte = pcs_pkg::CH_P;
                    3'd1:    emit_byte = cmd_reg.x_coord[7:0];
                    3'd2:    emit_byte = cmd_reg.x_coord[15:8];
                    3'd3:    emit_byte = cmd_reg.y_coord[7:0];
                    3'd4:    emit_byte = cmd_reg.y_coord[15:8];
                    3'd5:    emit_byte = cmd_reg.red;
                    3'd6:    emit_byte = cmd_reg.green;
                    default: emit_byte = cmd_reg.blue;
                endcase
            end
            default:          emit_byte = '0;
        endcase
    end

    // Next state: step through the command, chain the next one on the last byte
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            state_next = cmd_data.binary_mode ? pcs_pkg::ST_BIN : pcs_pkg::ST_HEAD;
            cnt_next   = '0;
        end
        else if (busy && out_free)
        begin
            unique case (state_reg)
                pcs_pkg::ST_HEAD:
                begin
                    if (cnt_reg == pcs_pkg::HEAD_LAST)
                    begin
                        state_next = pcs_pkg::ST_XDIG;
                        cnt_next   = cmd_reg.x_top;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                pcs_pkg::ST_XDIG:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = pcs_pkg::ST_SEP1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                pcs_pkg::ST_SEP1:
                begin
                    state_next = pcs_pkg::ST_YDIG;
                    cnt_next   = cmd_reg.y_top;
                end
                pcs_pkg::ST_YDIG:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = pcs_pkg::ST_SEP2;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                pcs_pkg::ST_SEP2:
                begin
                    state_next = pcs_pkg::ST_HEX;
                    cnt_next   = '0;
                end
                pcs_pkg::ST_HEX:
                begin
                    if (cnt_reg == pcs_pkg::HEX_LAST)
                    begin
                        state_next = pcs_pkg::ST_NL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                pcs_pkg::ST_NL:
                begin
                    state_next = pcs_pkg::ST_IDLE;
                end
                pcs_pkg::ST_BIN:
                begin
                    if (cnt_reg == pcs_pkg::BIN_LAST)
                    begin
                        state_next = pcs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_next = pcs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Hold sequencer state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcs_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_free)
            begin
                out_valid_reg <= busy;
            end
        end
    end

    // Capture command and byte payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd_data;
        end
        if (out_free)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= is_last;
        end
    end

    assign byte_out.valid     = out_valid_reg;
    assign byte_out.out_byte  = out_byte_reg;
    assign byte_out.last_byte = out_last_reg;

endmodule

`default_nettype wire

[rtl/core/pixel_command_serializer.sv]
// Top level of the pixel command serializer: config register, front end,
// command queue and byte sequencer. Depends on pcs_pkg, pcs_if and submodules.
`default_nettype none

// Each accepted pixel becomes one set-pixel command on the byte channel, one
// byte per cycle while the channel is ready, out of an output register. A text
// command ("PX x y rrggbb\n") has 12 bytes plus one per decimal digit of x and
// of y, so 14 to 22; a binary command has 8. An idle sequencer loads a command
// before its first byte; otherwise commands follow with no gap. Pixels pass a
// five-stage decimal conversion pipeline, one digit of x and y per stage, and a
// two-entry command queue, so the input keeps taking pixels while bytes go out
// until both are full. binary_mode (address 0) is sampled when a pixel is
// accepted and should be written only while the block is idle.

`include "pixel_command_serializer_assert.svh"

module pixel_command_serializer #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pcs_pixel_if.sink                       pixel_in,
    pcs_byte_if.source                      byte_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcs_pkg::PADDR_W-1:0]     paddr,
    input  logic [pcs_pkg::PDATA_W-1:0]     pwdata,
    output logic [pcs_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    logic              binary_mode_reg;
    logic              cfg_write;
    logic              fq_valid;
    logic              fq_ready;
    pcs_pkg::pcs_cmd_t fq_data;
    logic              bq_valid;
    logic              bq_ready;
    pcs_pkg::pcs_cmd_t bq_data;

    // Register write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == pcs_pkg::REG_BINARY_MODE))
        begin
            binary_mode_reg <= pwdata[0];
        end
    end

    // Read back the register, zero elsewhere
    assign prdata = (paddr[2] == pcs_pkg::REG_BINARY_MODE) ?
                    {{(pcs_pkg::PDATA_W-1){1'b0}}, binary_mode_reg} : '0;

    pcs_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .binary_mode (binary_mode_reg),
        .pixel_in    (pixel_in),
        .cmd_valid   (fq_valid),
        .cmd_ready   (fq_ready),
        .cmd_data    (fq_data)
    );

    pcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    pcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (bq_valid),
        .cmd_ready (bq_ready),
        .cmd_data  (bq_data),
        .byte_out  (byte_out)
    );

    // A full queue must stall the pixel input
    `PCS_ASSERT_IMP(a_full_queue_stalls_input, fq_valid && !fq_ready, !pixel_in.ready)
    // A blocked command stays at the end of the conversion pipeline
    `PCS_ASSERT_NXT(a_blocked_cmd_held, fq_valid && !fq_ready, fq_valid)
    // The byte after a command's last byte opens a new command
    `PCS_ASSERT_NXT(a_cmd_opens_with_p, byte_out.valid && byte_out.ready && byte_out.last_byte, !byte_out.valid || (byte_out.out_byte == pcs_pkg::CH_P))

endmodule

`default_nettype wire
